// ===== hw/rtl/sync_word_frame_capture_macros.svh =====
// assertion macros shared by the sync word frame capture rtl
// needs a clock and an active-low reset at each point of use
`ifndef SYNC_WORD_FRAME_CAPTURE_MACROS_SVH
`define SYNC_WORD_FRAME_CAPTURE_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define SWFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swfc assertion failed");

// antecedent implies consequent in the next cycle
`define SWFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swfc assertion failed");

`else

`define SWFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SWFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/swfc_pkg.sv =====
// types and constants for the sync word frame capture block
// no dependencies
`default_nettype none

package swfc_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_WORD    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH = 1'b1;

    localparam int SYNC_W     = 32;
    localparam int LEN_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SYNC_W-1:0] SYNC_WORD_RESET    = '0;
    localparam logic [LEN_W-1:0]  FRAME_LENGTH_RESET = 9'd64;
    localparam int                MAX_FRAME_DEFAULT  = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_last;
    } swfc_result_t;

    typedef struct packed {
        logic capturing;
        logic search_zero;
        logic bit_pos_zero;
        logic count_zero;
        logic emit;
        logic emit_last;
    } swfc_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swfc_in_stage.sv =====
// input register for the received bit stream
// depends on swfc_pkg
`default_nettype none

module swfc_in_stage (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [swfc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] rx_bit, rest zero
    output logic                              in_valid,
    output logic                              in_bit,
    input  wire                               take
);
    import swfc_pkg::*;

    logic valid_reg, valid_next;
    logic bit_reg, bit_next;

    assign s_tready = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_bit   = bit_reg;

    always_comb begin
        valid_next = valid_reg;
        bit_next   = bit_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            bit_next   = s_tdata[0];
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        bit_reg <= bit_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swfc_core.sv =====
// sync search, byte packing and result register
// depends on swfc_pkg
`default_nettype none

module swfc_core #(
    parameter int MAX_FRAME = swfc_pkg::MAX_FRAME_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire [swfc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [swfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                               in_valid,
    input  wire                               in_bit,
    output logic                              take,
    output logic                              out_valid,
    input  wire                               out_ready,
    output swfc_pkg::swfc_result_t            result,
    output swfc_pkg::swfc_status_t            status
);
    import swfc_pkg::*;

    localparam int CNT_RAW = $clog2(MAX_FRAME + 1);
    localparam int CNT_W   = (CNT_RAW > LEN_W) ? CNT_RAW : LEN_W;
    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME);

    logic [SYNC_W-1:0] sync_word_reg;
    logic [LEN_W-1:0]  frame_length_reg;

    logic [SYNC_W-1:0] search_reg, search_next;
    logic              capturing_reg, capturing_next;
    logic [BYTE_W-1:0] accum_reg, accum_next;
    logic [2:0]        bit_pos_reg, bit_pos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    swfc_result_t      result_reg, result_next;

    logic [SYNC_W-1:0] shifted;
    logic [SYNC_W-1:0] diff;
    logic              near_match;
    logic [CNT_W-1:0]  len_ext;
    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W:0]    count_inc;
    logic              last;
    logic              emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg    <= SYNC_WORD_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SYNC_WORD:    sync_word_reg    <= cfg_wdata[SYNC_W-1:0];
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_wdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign take = in_valid && (!out_valid_reg || out_ready);

    // one bit error allowed: the difference has at most one bit set
    assign shifted    = {search_reg[SYNC_W-2:0], in_bit};
    assign diff       = shifted ^ sync_word_reg;
    assign near_match = (diff & (diff - SYNC_W'(1))) == '0;

    // zero length means one byte, long lengths saturate
    assign len_ext = CNT_W'(frame_length_reg);
    always_comb begin
        priority if (len_ext == '0) eff_len = CNT_W'(1);
        else if (len_ext > MAX_LEN) eff_len = MAX_LEN;
        else                        eff_len = len_ext;
    end

    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign last      = count_inc >= {1'b0, eff_len};
    assign emit      = take && capturing_reg && (bit_pos_reg == 3'd7);

    always_comb begin
        search_next    = search_reg;
        capturing_next = capturing_reg;
        accum_next     = accum_reg;
        bit_pos_next   = bit_pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (take) begin
            if (!capturing_reg) begin
                search_next = shifted;
                if (near_match) begin
                    capturing_next = 1'b1;
                    search_next    = '0;
                    accum_next     = '0;
                    bit_pos_next   = '0;
                    count_next     = '0;
                end
            end else begin
                accum_next   = {accum_reg[BYTE_W-2:0], in_bit};
                bit_pos_next = bit_pos_reg + 3'd1;
                if (emit) begin
                    out_valid_next         = 1'b1;
                    result_next.frame_byte = {accum_reg[BYTE_W-2:0], in_bit};
                    result_next.byte_index = count_reg[BYTE_W-1:0];
                    result_next.frame_last = last;
                    accum_next             = '0;
                    count_next             = count_inc[CNT_W-1:0];
                    if (last) begin
                        capturing_next = 1'b0;
                        count_next     = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_reg    <= '0;
            capturing_reg <= 1'b0;
            accum_reg     <= '0;
            bit_pos_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            search_reg    <= search_next;
            capturing_reg <= capturing_next;
            accum_reg     <= accum_next;
            bit_pos_reg   <= bit_pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign status.capturing    = capturing_reg;
    assign status.search_zero  = (search_reg == '0);
    assign status.bit_pos_zero = (bit_pos_reg == '0);
    assign status.count_zero   = (count_reg == '0);
    assign status.emit         = emit;
    assign status.emit_last    = emit && last;

endmodule

`default_nettype wire

// ===== hw/rtl/sync_word_frame_capture.sv =====
// Sync word frame capture. Takes one received bit per beat on the s_ channel and
// searches for a 32-bit sync word with up to one bit in error; on a hit it packs
// the following bits MSB first into bytes and sends frame_length bytes (zero taken
// as one, saturated at MAX_FRAME) on the m_ channel, with index and a last flag,
// then searches again. A bit is accepted every cycle while the result register is not
// held full by m_tready low; the byte a beat completes passes the input register and
// then the result register, around the combinational search and packing logic.
// Configuration writes take effect at once and are meant for idle periods.
// depends on swfc_pkg, swfc_in_stage, swfc_core and the macros header
`default_nettype none

`include "sync_word_frame_capture_macros.svh"

module sync_word_frame_capture #(
    parameter int MAX_FRAME = swfc_pkg::MAX_FRAME_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire [swfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire [swfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [swfc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] rx_bit
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [swfc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] frame_byte, [15:8] byte_index
    output logic                               m_tlast    // frame_last
);
    import swfc_pkg::*;

    logic         in_valid;
    logic         in_bit;
    logic         take;
    swfc_result_t result;
    swfc_status_t status;

    swfc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_bit   (in_bit),
        .take     (take)
    );

    swfc_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_bit    (in_bit),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result),
        .status    (status)
    );

    assign m_tdata = {result.byte_index, result.frame_byte};
    assign m_tlast = result.frame_last;

    // searching implies the byte packer sits at the start of a frame
    `SWFC_ASSERT_NOW(a_idle_clear, aclk, aresetn, !status.capturing, status.bit_pos_zero && status.count_zero)
    // the search register is held empty for the whole capture
    `SWFC_ASSERT_NOW(a_search_held, aclk, aresetn, status.capturing, status.search_zero)
    // the last byte of a frame returns the block to searching
    `SWFC_ASSERT_NEXT(a_last_ends, aclk, aresetn, status.emit_last, !status.capturing && m_tvalid && m_tlast)
    // input only stalls behind a full result register
    `SWFC_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

endmodule

`default_nettype wire

// ===== dv/tb_sync_word_frame_capture.sv =====
// testbench for sync_word_frame_capture: bit stream in, captured frame bytes out
// needs swfc_pkg and the block's rtl; self-contained scoreboard class below
`timescale 1ns / 100ps

module tb_sync_word_frame_capture;
    import swfc_pkg::*;

    // tracks the block's search and capture state and queues the frame bytes it should send
    class frame_byte_board;
        logic [SYNC_W-1:0] sync_pattern;
        logic [LEN_W-1:0]  frame_len;
        logic [SYNC_W-1:0] search_reg;
        bit                in_frame;
        logic [BYTE_W-1:0] accum;
        logic [2:0]        bit_pos;
        int                bytes_done;
        swfc_result_t      expected_bytes[$];
        int                errors;
        int                bits_taken;
        int                bytes_checked;
        int                frames_closed;
        int                reg_writes;

        function new();
            sync_pattern = SYNC_WORD_RESET;
            frame_len = FRAME_LENGTH_RESET;
            search_reg = '0;
            in_frame = 1'b0;
            accum = '0;
            bit_pos = '0;
            bytes_done = 0;
            errors = 0;
            bits_taken = 0;
            bytes_checked = 0;
            frames_closed = 0;
            reg_writes = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_SYNC_WORD)
                sync_pattern = val[SYNC_W-1:0];
            else if (idx == CFG_FRAME_LENGTH)
                frame_len = val[LEN_W-1:0];
            reg_writes++;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // one accepted input beat
        function void take_bit(bit b);
            logic [SYNC_W-1:0] diff;
            int                limit;
            swfc_result_t      r;
            bits_taken++;
            if (!in_frame) begin
                search_reg = {search_reg[SYNC_W-2:0], b};
                diff = search_reg ^ sync_pattern;
                // zero or a single set bit: at most one bit in error
                if ((diff & (diff - 1)) == '0) begin
                    in_frame = 1'b1;
                    search_reg = '0;
                    accum = '0;
                    bit_pos = '0;
                    bytes_done = 0;
                end
                return;
            end
            accum = {accum[BYTE_W-2:0], b};
            bit_pos = bit_pos + 3'd1;
            if (bit_pos != 3'd0)
                return;
            if (frame_len == '0)
                limit = 1;
            else if (int'(frame_len) > MAX_FRAME_DEFAULT)
                limit = MAX_FRAME_DEFAULT;
            else
                limit = int'(frame_len);
            r.frame_byte = accum;
            r.byte_index = bytes_done[7:0];
            r.frame_last = (bytes_done + 1 >= limit);
            expected_bytes.push_back(r);
            bytes_done++;
            accum = '0;
            if (r.frame_last) begin
                in_frame = 1'b0;
                bytes_done = 0;
                frames_closed++;
            end
        endfunction

        function void check_byte(logic [OUT_TDATA_W-1:0] data, logic last);
            swfc_result_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result beat: frame_byte %02h byte_index %0d frame_last %0b",
                       data[7:0], data[15:8], last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (data[7:0] !== want.frame_byte) begin
                $error("frame_byte mismatch: expected %02h, actual %02h",
                       want.frame_byte, data[7:0]);
                errors++;
            end
            if (data[15:8] !== want.byte_index) begin
                $error("byte_index mismatch: expected %0d, actual %0d",
                       want.byte_index, data[15:8]);
                errors++;
            end
            if (last !== want.frame_last) begin
                $error("frame_last mismatch: expected %0b, actual %0b", want.frame_last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [0] rx_bit
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] frame_byte, [15:8] byte_index
    logic                   m_tlast;          // frame_last

    frame_byte_board board;
    int              burst_left = 0;
    int              ready_hold = 0;

    sync_word_frame_capture dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // receiver: long ready stretches, short stalls and bursts of toggling
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b0;
                    ready_hold <= $urandom_range(1, 12);
                end
                1: begin
                    m_tready <= 1'b1;
                    ready_hold <= $urandom_range(50, 300);
                end
                default: begin
                    m_tready <= ~m_tready;
                    ready_hold <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            board.check_byte(m_tdata, m_tlast);
    end

    task automatic send_bit(input bit b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W-1){1'b0}}, b};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.take_bit(b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // msb first
    task automatic send_word(input logic [31:0] v, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            send_bit(v[i]);
    endtask

    // block idle: no bytes owed and the input pipeline flushed
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_sync();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0]      sync_val;
        logic [31:0]      flip;
        logic [LEN_W-1:0] len9;
        int               eff;
        int               nseq;
        int               kind;
        int               nbytes;

        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // length zero acts as one byte; a zero sync word hits on the first bit searched
        cfg_write(CFG_FRAME_LENGTH, 32'hFFFF_FE00);
        send_bit(1'b0);
        send_word(32'h96, 8);
        send_bit(1'b1);
        send_word(32'hFF, 8);
        send_bit(1'b0);
        send_word(32'h00, 8);

        // oversize length saturates and keeps the frame open; a lower length then closes it
        settle();
        cfg_write(CFG_SYNC_WORD, 32'hFFFF_FFFF);
        cfg_write(CFG_FRAME_LENGTH, ($urandom & 32'hFFFF_FE00) | 32'h1FF);
        send_word(32'hFFFF_FFFF, 32);
        repeat (12) send_word($urandom, 8);
        settle();
        cfg_write(CFG_FRAME_LENGTH, 32'd13);
        send_word($urandom, 8);

        // shorten the length and swap the sync word part way through a frame
        settle();
        sync_val = $urandom;
        cfg_write(CFG_SYNC_WORD, sync_val);
        cfg_write(CFG_FRAME_LENGTH, 32'd200);
        send_word(sync_val, 32);
        repeat (10) send_word($urandom, 8);
        settle();
        sync_val = $urandom;
        cfg_write(CFG_FRAME_LENGTH, 32'd3);
        cfg_write(CFG_SYNC_WORD, sync_val);
        send_word($urandom, 8);
        send_word(sync_val, 32);
        repeat (3) send_word($urandom, 8);

        while (board.bits_taken < 1650) begin
            settle();
            sync_val = pick_sync();
            case ($urandom_range(0, 11))
                0: len9 = '0;
                1: len9 = 9'd1;
                2: len9 = LEN_W'($urandom_range(9, 40));
                default: len9 = LEN_W'($urandom_range(1, 6));
            endcase
            eff = (len9 == '0) ? 1 : int'(len9);
            if ($urandom_range(0, 1)) begin
                cfg_write(CFG_SYNC_WORD, sync_val);
                cfg_write(CFG_FRAME_LENGTH, ($urandom & 32'hFFFF_FE00) | len9);
            end else begin
                cfg_write(CFG_FRAME_LENGTH, ($urandom & 32'hFFFF_FE00) | len9);
                cfg_write(CFG_SYNC_WORD, sync_val);
            end
            nseq = $urandom_range(2, 6);
            repeat (nseq) begin
                kind = $urandom_range(0, 9);
                if (kind < 2) begin
                    send_word($urandom, $urandom_range(1, 32));
                end else begin
                    send_word($urandom, $urandom_range(0, 16));
                    // mostly clean or one bit off; two bits off should not lock
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6: flip = 32'h1 << $urandom_range(0, 31);
                        7, 8, 9: flip = (32'h1 << $urandom_range(0, 31))
                                      | (32'h1 << $urandom_range(0, 31));
                        default: flip = '0;
                    endcase
                    send_word(sync_val ^ flip, 32);
                    nbytes = (kind == 2) ? $urandom_range(0, eff) : eff;
                    // a sync word inside the payload must not restart the frame
                    if (nbytes >= 4 && $urandom_range(0, 4) == 0) begin
                        send_word(sync_val, 32);
                        nbytes -= 4;
                    end
                    repeat (nbytes) send_word($urandom, 8);
                    if (kind == 2)
                        send_word($urandom, $urandom_range(0, 7));
                end
            end
        end

        settle();
        $display("sent %0d bits, checked %0d bytes over %0d closed frames, %0d register writes",
                 board.bits_taken, board.bytes_checked, board.frames_closed, board.reg_writes);
        if (board.errors == 0)
            $display("sync_word_frame_capture test passed");
        else
            $display("sync_word_frame_capture test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sync_word_frame_capture test failed");
        $finish;
    end

endmodule
